// File: sv/pdh_pkg.sv
package pdh_pkg;

    // Field widths of the pedal sample and of the drive result.
    localparam int unsigned PCT_IN_W = 8;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned DUTY_W   = 14;
    localparam int unsigned SDUTY_W  = 15;
    localparam int unsigned DB_W     = 7;

    // Largest duty ceiling that a register write may store.
    localparam int unsigned DUTY_LIMIT = 10000;

    // Full pedal in percent.
    localparam logic [PCT_IN_W-1:0] PCT_FULL = PCT_IN_W'(100);

    // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
    // The error stays below one unit for every product of percent and ceiling.
    localparam int unsigned RECIP_SHIFT = 27;
    localparam int unsigned RECIP_K     = ((2 ** RECIP_SHIFT) + 99) / 100;
    localparam int unsigned RECIP_W     = 21;
    localparam int unsigned SCALE_W     = DUTY_W + RECIP_W;
    localparam int unsigned PROD_W      = SCALE_W + PCT_W;

    // Reset values of the configuration registers.
    localparam logic [DUTY_W-1:0]  CEIL_RESET  = DUTY_W'(DUTY_LIMIT % (2 ** DUTY_W));
    localparam logic [SCALE_W-1:0] SCALE_RESET =
        SCALE_W'(CEIL_RESET) * SCALE_W'(RECIP_K);
    localparam logic [DB_W-1:0]    DB_RESET    = DB_W'(5);

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_ENABLE   = 2'd0,
        REG_REVERSE  = 2'd1,
        REG_CEILING  = 2'd2,
        REG_DEADBAND = 2'd3
    } t_reg_idx;

    // Drive sign that each channel keeps.
    typedef enum logic [1:0] {
        SIGN_STOP = 2'd0,
        SIGN_FWD  = 2'd1,
        SIGN_REV  = 2'd2
    } t_sign;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic               enable;
        logic               reverse;
        logic [DB_W-1:0]    deadband;
        logic [SCALE_W-1:0] scale;
        logic               sign_clr;
    } t_cfg;

    // Per-beat command to a drive channel.
    typedef struct packed {
        logic              step;
        logic              clear;
        logic              run;
        t_sign             tgt;
        logic [DUTY_W-1:0] mag;
    } t_chan_cmd;

endpackage

// File: sv/pdh_cfg.sv
module pdh_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output pdh_pkg::t_cfg       o_cfg
);

    logic                          r_enable;
    logic                          r_reverse;
    logic [pdh_pkg::DUTY_W-1:0]    r_ceiling;
    logic [pdh_pkg::SCALE_W-1:0]   r_scale;
    logic [pdh_pkg::DB_W-1:0]      r_deadband;

    logic                          w_wr;
    pdh_pkg::t_reg_idx             w_idx;
    logic [pdh_pkg::DUTY_W-1:0]    w_ceil_lim;
    logic [pdh_pkg::SCALE_W-1:0]   w_scale;
    logic                          w_sign_clr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = pdh_pkg::t_reg_idx'(paddr[3:2]);

    // A ceiling write keeps the low 14 bits and saturates to the duty limit.
    assign w_ceil_lim = ({3'b000, pwdata[pdh_pkg::DUTY_W-1:0]} >
                         17'(pdh_pkg::DUTY_LIMIT)) ?
                        pdh_pkg::DUTY_W'(pdh_pkg::DUTY_LIMIT) :
                        pwdata[pdh_pkg::DUTY_W-1:0];

    // The ceiling is kept premultiplied by the reciprocal of 100.
    assign w_scale = pdh_pkg::SCALE_W'(w_ceil_lim) *
                     pdh_pkg::SCALE_W'(pdh_pkg::RECIP_K);

    // Enable and direction writes clear both channel signs at the write edge.
    assign w_sign_clr = w_wr && ((w_idx == pdh_pkg::REG_ENABLE) ||
                                 (w_idx == pdh_pkg::REG_REVERSE));

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_reverse  <= 1'b0;
            r_ceiling  <= pdh_pkg::CEIL_RESET;
            r_scale    <= pdh_pkg::SCALE_RESET;
            r_deadband <= pdh_pkg::DB_RESET;
        end else begin
            if (w_wr) begin
                unique case (w_idx)
                    pdh_pkg::REG_ENABLE: begin
                        r_enable   <= pwdata[0];
                    end
                    pdh_pkg::REG_REVERSE: begin
                        r_reverse  <= pwdata[0];
                    end
                    pdh_pkg::REG_CEILING: begin
                        r_ceiling <= w_ceil_lim;
                        r_scale   <= w_scale;
                    end
                    pdh_pkg::REG_DEADBAND: begin
                        r_deadband <= pwdata[pdh_pkg::DB_W-1:0];
                    end
                endcase
            end
        end
    end

    // Read-back multiplexer.
    always_comb begin
        prdata = 32'd0;
        unique case (w_idx)
            pdh_pkg::REG_ENABLE:   prdata = {31'd0, r_enable};
            pdh_pkg::REG_REVERSE:  prdata = {31'd0, r_reverse};
            pdh_pkg::REG_CEILING:  prdata = 32'(r_ceiling);
            pdh_pkg::REG_DEADBAND: prdata = 32'(r_deadband);
        endcase
    end

    assign o_cfg.enable   = r_enable;
    assign o_cfg.reverse  = r_reverse;
    assign o_cfg.deadband = r_deadband;
    assign o_cfg.scale    = r_scale;
    assign o_cfg.sign_clr = w_sign_clr;

endmodule

// File: sv/pdh_chan.sv
module pdh_chan (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pdh_pkg::t_chan_cmd                 i_cmd,
    output logic [pdh_pkg::DUTY_W-1:0]         o_fwd,
    output logic [pdh_pkg::DUTY_W-1:0]         o_rev,
    output logic signed [pdh_pkg::SDUTY_W-1:0] o_sgn
);

    pdh_pkg::t_sign r_sign;
    pdh_pkg::t_sign n_sign;
    logic           w_flip;

    // A request against the kept sign is a reversal.
    assign w_flip = (r_sign != pdh_pkg::SIGN_STOP) && (r_sign != i_cmd.tgt);

    // Duty selection and next sign for this beat.
    always_comb begin
        n_sign = r_sign;
        o_fwd  = '0;
        o_rev  = '0;
        o_sgn  = '0;
        if (!i_cmd.run || (i_cmd.mag == '0) || w_flip) begin
            // Stopped, zero duty, or the idle step of a reversal.
            n_sign = pdh_pkg::SIGN_STOP;
        end else begin
            n_sign = i_cmd.tgt;
            if (i_cmd.tgt == pdh_pkg::SIGN_FWD) begin
                o_fwd = i_cmd.mag;
                o_sgn = $signed({1'b0, i_cmd.mag});
            end else begin
                o_rev = i_cmd.mag;
                o_sgn = -$signed({1'b0, i_cmd.mag});
            end
        end
    end

    // Sign register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign <= pdh_pkg::SIGN_STOP;
        end else if (i_cmd.clear) begin
            r_sign <= pdh_pkg::SIGN_STOP;
        end else if (i_cmd.step) begin
            r_sign <= n_sign;
        end
    end

endmodule

// File: sv/pedal_to_hbridge_drive_top.sv
// An accepted pedal beat is held in the input register and then in the result register.
// Throughput: one beat per cycle while the result side accepts; one input register and one
// result register, with a single multiply by the premultiplied ceiling between them.
// Reset (synchronous, active low) empties both registers, stops both channels,
// and loads the configuration defaults: disabled, forward, full ceiling, deadband 5.
module pedal_to_hbridge_drive_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pedal input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] pedal_percent
    input  logic [0:0]  i_s_axis_tuser,  // [0] pedal_valid
    // Drive result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [6:0] pedal_shown, [20:7] left_fwd_duty, [34:21] left_rev_duty,
    // [48:35] right_fwd_duty, [62:49] right_rev_duty,
    // [77:63] left_signed_duty, [92:78] right_signed_duty, [95:93] zero
    output logic [95:0] o_m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pdh_pkg::t_cfg                      w_cfg;
    pdh_pkg::t_chan_cmd                 w_cmd;

    logic                               r_in_valid;
    logic                               r_in_pvalid;
    logic [pdh_pkg::PCT_IN_W-1:0]       r_in_pct;

    logic                               r_out_valid;
    logic [pdh_pkg::PCT_W-1:0]          r_out_pct;
    logic [pdh_pkg::DUTY_W-1:0]         r_lf;
    logic [pdh_pkg::DUTY_W-1:0]         r_lr;
    logic [pdh_pkg::DUTY_W-1:0]         r_rf;
    logic [pdh_pkg::DUTY_W-1:0]         r_rr;
    logic signed [pdh_pkg::SDUTY_W-1:0] r_ls;
    logic signed [pdh_pkg::SDUTY_W-1:0] r_rs;

    logic                               w_adv;
    logic                               w_s_acc;
    logic [pdh_pkg::PCT_W-1:0]          w_pct;
    logic [pdh_pkg::PROD_W-1:0]         w_prod;
    logic                               w_run;
    logic [pdh_pkg::DUTY_W-1:0]         w_lf;
    logic [pdh_pkg::DUTY_W-1:0]         w_lr;
    logic [pdh_pkg::DUTY_W-1:0]         w_rf;
    logic [pdh_pkg::DUTY_W-1:0]         w_rr;
    logic signed [pdh_pkg::SDUTY_W-1:0] w_ls;
    logic signed [pdh_pkg::SDUTY_W-1:0] w_rs;

    pdh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: the input register moves on whenever the result register is empty or being taken.
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_pvalid <= i_s_axis_tuser[0];
            r_in_pct    <= i_s_axis_tdata;
        end
    end

    // Percent clamp; an invalid sample reads as zero.
    always_comb begin
        w_pct = '0;
        if (r_in_pvalid) begin
            w_pct = (r_in_pct > pdh_pkg::PCT_FULL) ?
                    pdh_pkg::PCT_W'(pdh_pkg::PCT_FULL) : r_in_pct[pdh_pkg::PCT_W-1:0];
        end
    end

    // Stop decision and duty magnitude: percent times ceiling over 100.
    assign w_run  = w_cfg.enable && r_in_pvalid && (w_pct >= w_cfg.deadband);
    assign w_prod = pdh_pkg::PROD_W'(w_pct) * pdh_pkg::PROD_W'(w_cfg.scale);

    assign w_cmd.step  = w_adv;
    assign w_cmd.clear = w_cfg.sign_clr;
    assign w_cmd.run   = w_run;
    assign w_cmd.tgt   = w_cfg.reverse ? pdh_pkg::SIGN_REV : pdh_pkg::SIGN_FWD;
    assign w_cmd.mag   =
        w_prod[pdh_pkg::RECIP_SHIFT+pdh_pkg::DUTY_W-1:pdh_pkg::RECIP_SHIFT];

    pdh_chan u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_fwd   (w_lf),
        .o_rev   (w_lr),
        .o_sgn   (w_ls)
    );

    pdh_chan u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_fwd   (w_rf),
        .o_rev   (w_rr),
        .o_sgn   (w_rs)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_pct <= w_pct;
            r_lf      <= w_lf;
            r_lr      <= w_lr;
            r_rf      <= w_rf;
            r_rr      <= w_rr;
            r_ls      <= w_ls;
            r_rs      <= w_rs;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_rs, r_ls, r_rr, r_rf, r_lr, r_lf, r_out_pct};

    // A channel never drives both directions in one beat.
    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !((r_lf != '0) && (r_lr != '0)))
        else $error("left channel drives forward and reverse at once");

    // The signed duty agrees with the forward and reverse duties.
    a_signed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_ls == ($signed({1'b0, r_lf}) - $signed({1'b0, r_lr}))))
        else $error("left signed duty disagrees with its direction duties");

    // Both channels see the same commands and must stay in step.
    a_chan_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_ls == r_rs) && (r_lf == r_rf) && (r_lr == r_rr))
        else $error("left and right channels diverged");

    // The shown percent is clamped to full pedal.
    a_pct_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pct <= pdh_pkg::PCT_W'(pdh_pkg::PCT_FULL)))
        else $error("shown pedal percent above full pedal");

endmodule

// File: tb/sv/pedal_to_hbridge_drive_top_test.sv
`timescale 1ns / 100ps

module pedal_to_hbridge_drive_top_test;

    import pdh_pkg::*;

    localparam int unsigned PCT_MAX     = 100;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 4;

    // One drive beat as packed on the result tdata, lowest field last.
    typedef struct packed {
        logic [SDUTY_W-1:0] right_signed;
        logic [SDUTY_W-1:0] left_signed;
        logic [DUTY_W-1:0]  right_rev;
        logic [DUTY_W-1:0]  right_fwd;
        logic [DUTY_W-1:0]  left_rev;
        logic [DUTY_W-1:0]  left_fwd;
        logic [PCT_W-1:0]   shown;
    } drive_beat_t;

    // Tracks configuration and channel signs, predicts each drive beat and
    // compares the block's beats against the oldest prediction.
    class drive_scoreboard;
        logic              enable;
        logic              reverse;
        logic [DUTY_W-1:0] ceiling;
        logic [DB_W-1:0]   deadband;
        t_sign             left_sign;
        t_sign             right_sign;
        drive_beat_t       expected_drive[$];
        int                errors;

        function new();
            enable     = 1'b0;
            reverse    = 1'b0;
            ceiling    = CEIL_RESET;
            deadband   = DB_RESET;
            left_sign  = SIGN_STOP;
            right_sign = SIGN_STOP;
            errors     = 0;
        endfunction

        function void note_write(t_reg_idx idx, logic [31:0] value);
            logic [DUTY_W-1:0] ceil_v;
            case (idx)
                REG_ENABLE: begin
                    enable     = value[0];
                    left_sign  = SIGN_STOP;
                    right_sign = SIGN_STOP;
                end
                REG_REVERSE: begin
                    reverse    = value[0];
                    left_sign  = SIGN_STOP;
                    right_sign = SIGN_STOP;
                end
                REG_CEILING: begin
                    ceil_v  = value[DUTY_W-1:0];
                    ceiling = (ceil_v > DUTY_LIMIT) ? DUTY_W'(DUTY_LIMIT) : ceil_v;
                end
                REG_DEADBAND: begin
                    deadband = value[DB_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // A channel drives only when it was stopped or already runs the same way;
        // a reversal costs one all-zero beat with the sign cleared.
        function void predict_channel(inout t_sign sign, input t_sign tgt,
                                      input logic [DUTY_W-1:0] mag,
                                      output logic [DUTY_W-1:0] fwd,
                                      output logic [DUTY_W-1:0] rev,
                                      output logic [SDUTY_W-1:0] sgn);
            fwd = '0;
            rev = '0;
            sgn = '0;
            if (mag == 0 || tgt == SIGN_STOP) begin
                sign = SIGN_STOP;
            end else if (sign != SIGN_STOP && sign != tgt) begin
                sign = SIGN_STOP;
            end else begin
                sign = tgt;
                if (tgt == SIGN_FWD) begin
                    fwd = mag;
                    sgn = SDUTY_W'(mag);
                end else begin
                    rev = mag;
                    sgn = -SDUTY_W'(mag);
                end
            end
        endfunction

        function void note_pedal(logic valid, logic [PCT_IN_W-1:0] pct);
            drive_beat_t want;
            int unsigned shown;
            int unsigned mag;
            t_sign       tgt;
            want  = '0;
            shown = valid ? int'(pct) : 0;
            if (shown > PCT_MAX) shown = PCT_MAX;
            want.shown = PCT_W'(shown);
            if (!enable || !valid || shown < deadband) begin
                left_sign  = SIGN_STOP;
                right_sign = SIGN_STOP;
            end else begin
                mag = shown * ceiling / PCT_MAX;
                tgt = reverse ? SIGN_REV : SIGN_FWD;
                predict_channel(left_sign, tgt, DUTY_W'(mag),
                                want.left_fwd, want.left_rev, want.left_signed);
                predict_channel(right_sign, tgt, DUTY_W'(mag),
                                want.right_fwd, want.right_rev, want.right_signed);
            end
            expected_drive.push_back(want);
        endfunction

        function void compare_field(string name, int want_v, int got_v);
            if (want_v != got_v) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            end
        endfunction

        function void check_drive(logic [95:0] data);
            drive_beat_t want;
            drive_beat_t got;
            got = data[$bits(drive_beat_t)-1:0];
            if (expected_drive.size() == 0) begin
                errors++;
                $display("%0t: drive beat expected none actual %h", $time, data);
                return;
            end
            want = expected_drive.pop_front();
            compare_field("pedal_shown", want.shown, got.shown);
            compare_field("left_fwd_duty", want.left_fwd, got.left_fwd);
            compare_field("left_rev_duty", want.left_rev, got.left_rev);
            compare_field("right_fwd_duty", want.right_fwd, got.right_fwd);
            compare_field("right_rev_duty", want.right_rev, got.right_rev);
            compare_field("left_signed_duty", $signed(want.left_signed),
                          $signed(got.left_signed));
            compare_field("right_signed_duty", $signed(want.right_signed),
                          $signed(got.right_signed));
            compare_field("tdata padding", 0, data[95:$bits(drive_beat_t)]);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire [95:0]  o_m_axis_tdata;
    wire [31:0]  prdata;
    wire         pready;

    drive_scoreboard sb = new();
    int src_idle    = 0;
    int dst_idle    = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    pedal_to_hbridge_drive_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] pedal_percent
        .i_s_axis_tuser  (s_tuser),   // [0] pedal_valid
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock and cycle budget.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Result side: check each accepted beat, then pick tready for the next
    // cycle. A pending hold-off keeps tready low for its whole length.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && m_tready) begin
                sb.check_drive(o_m_axis_tdata);
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle);
            end
        end
    end

    // Offer one pedal beat, with random idle cycles ahead of it.
    task automatic push_pedal(input logic valid, input logic [7:0] pct);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pct;
        s_tuser  <= valid;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pedal(valid, pct);
    endtask

    // Random pedal beat, weighted toward the deadband edge and full travel.
    task automatic random_pedal();
        logic       valid;
        logic [7:0] pct;
        int         pick;
        int         near;
        valid = 1'b1;
        pick  = $urandom_range(9);
        case (pick)
            0: begin
                valid = 1'b0;
                pct   = 8'($urandom);
            end
            1, 2: pct = 8'($urandom);
            3, 4, 5: begin
                near = int'(sb.deadband) + int'($urandom_range(4)) - 2;
                if (near < 0) near = 0;
                if (near > 255) near = 255;
                pct = 8'(near);
            end
            6, 7, 8: pct = 8'($urandom_range(0, PCT_MAX));
            default: pct = 8'($urandom_range(PCT_MAX, 255));
        endcase
        push_pedal(valid, pct);
    endtask

    // Register write: setup cycle, then access cycle until pready. The bus is
    // released only after the last write of a group.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value,
                             input bit last);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.note_write(idx, value);
        if (last) begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Stop offering, wait for every predicted beat, then let the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] ceil_v;
        logic [31:0] db_v;
        logic [31:0] en_v;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: disabled after reset, then thresholds, saturation and
        // invalid samples with the block enabled.
        push_pedal(1'b1, 8'd50);
        drain();
        write_reg(REG_ENABLE, 32'd1, 1'b1);
        push_pedal(1'b1, 8'd0);
        push_pedal(1'b1, 8'd4);
        push_pedal(1'b1, 8'd5);
        push_pedal(1'b1, 8'd100);
        push_pedal(1'b1, 8'd101);
        push_pedal(1'b1, 8'd255);
        push_pedal(1'b0, 8'd80);
        push_pedal(1'b0, 8'd255);
        push_pedal(1'b1, 8'd50);

        // Backward drive.
        drain();
        write_reg(REG_REVERSE, 32'd1, 1'b1);
        push_pedal(1'b1, 8'd100);
        push_pedal(1'b1, 8'd60);

        // A ceiling of one maps everything short of full pedal to zero duty.
        drain();
        write_reg(REG_CEILING, 32'd1, 1'b1);
        push_pedal(1'b1, 8'd99);
        push_pedal(1'b1, 8'd100);

        // Oversized ceiling saturates; a deadband above full pedal never runs.
        drain();
        write_reg(REG_CEILING, 32'hFFFF_FFFF, 1'b0);
        write_reg(REG_DEADBAND, 32'hFFFF_FFFF, 1'b1);
        push_pedal(1'b1, 8'd100);

        // Zero deadband: a zero percent still gives zero duty.
        drain();
        write_reg(REG_DEADBAND, 32'd0, 1'b1);
        push_pedal(1'b1, 8'd0);
        push_pedal(1'b1, 8'd1);

        // Only the low 14 bits of a ceiling write count.
        drain();
        write_reg(REG_CEILING, 32'd20000, 1'b1);
        push_pedal(1'b1, 8'd77);

        // Only the low bit of an enable write counts.
        drain();
        write_reg(REG_ENABLE, 32'd2, 1'b1);
        push_pedal(1'b1, 8'd50);

        // Long receiver hold-off while the sender keeps offering beats.
        drain();
        write_reg(REG_ENABLE, 32'd1, 1'b0);
        write_reg(REG_REVERSE, 32'd0, 1'b0);
        write_reg(REG_CEILING, DUTY_LIMIT, 1'b0);
        write_reg(REG_DEADBAND, 32'd5, 1'b1);
        src_idle  = 0;
        dst_idle  = 0;
        hold_left = 150;
        repeat (30) random_pedal();

        // Random phases, each with a fresh configuration.
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            if (phase < 3) begin
                src_idle = 30;
                dst_idle = 62;
            end else if (phase < 6) begin
                src_idle = 62;
                dst_idle = 30;
            end else begin
                src_idle = 0;
                dst_idle = 0;
            end
            en_v    = $urandom;
            en_v[0] = ($urandom_range(7) != 0);
            case ($urandom_range(5))
                0: ceil_v = 32'd0;
                1: ceil_v = DUTY_LIMIT;
                2: ceil_v = $urandom_range(1, 200);
                3: ceil_v = $urandom_range(0, DUTY_LIMIT);
                4: ceil_v = $urandom;
                default: ceil_v = 32'd16383;
            endcase
            case ($urandom_range(4))
                0: db_v = 32'd0;
                1: db_v = $urandom_range(0, 20);
                2: db_v = $urandom_range(0, PCT_MAX);
                3: db_v = $urandom_range(PCT_MAX, 127);
                default: db_v = $urandom;
            endcase
            if (phase == 0) begin
                ceil_v = DUTY_LIMIT;
                db_v   = 32'd0;
            end
            write_reg(REG_ENABLE, en_v, 1'b0);
            write_reg(REG_REVERSE, $urandom, 1'b0);
            write_reg(REG_CEILING, ceil_v, 1'b0);
            write_reg(REG_DEADBAND, db_v, 1'b1);
            repeat (50) random_pedal();
        end

        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
